[hdl/psb_pkg.sv]
// shared constants for the prime sieve bitmap block
package psb_pkg;

  localparam int CAND_W  = 16;
  localparam int PRIME_W = 16;
  localparam int MARK_W  = 24;
  localparam int ROW_W   = 8;

  localparam logic [CAND_W-1:0]  CAND_MIN    = 16'd2;
  localparam logic [CAND_W-1:0]  LIMIT_RESET = 16'd10000;
  localparam logic [PRIME_W-1:0] PRIME_MAX   = 16'hffff;
  localparam logic [MARK_W-1:0]  MARK_MAX    = 24'hffffff;

  // map rows keep the lowest number of the row in the top bit
  localparam logic [ROW_W-1:0] ROW_MSB  = 8'h80;
  localparam logic [ROW_W-1:0] ROW_FULL = 8'hff;

endpackage

[hdl/psb_ram.sv]
// generic simple dual-port ram with registered read
module psb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8192
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

[hdl/prime_sieve_bitmap.sv]
// prime sieve over a one-bit-per-number map, top level
//
//  channel  | direction | handshake                 | payload
//  in_      | slave     | in_tvalid / in_tready     | tdata: candidate; tuser: start_run
//  out_     | master    | out_tvalid / out_tready   | tdata: prime_count, mark_count;
//           |           |                           | tuser: is_prime, out_of_range
//  cfg_     | write     | cfg_wr_en                 | cfg_wr_data: upper_limit
//
// one item at a time: an out-of-range candidate skips the map test, a composite one is
// tested only, and a prime then clears p and its multiples up to the limit, one clear
// per cycle from one read-modify-write path on the map ram; row changes are folded into the clear cycle.
// start_run and reset sweep the map, one 8-bit row a cycle over (min(MAX_NUMBER,
// 65535) + 8) / 8 rows, 8192 at the default, with in_tready low meanwhile.
// the result sits in an output register, so a stalled out_ side holds only the next item.
module prime_sieve_bitmap #(
  parameter int unsigned MAX_NUMBER = 65535
) (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  logic                                     in_tvalid,
  output logic                                     in_tready,
  input  logic [psb_pkg::CAND_W-1:0]               in_tdata,    // [15:0] candidate
  input  logic                                     in_tuser,    // [0] start_run
  output logic                                     out_tvalid,
  input  logic                                     out_tready,
  output logic [psb_pkg::PRIME_W+psb_pkg::MARK_W-1:0] out_tdata, // [15:0] prime_count,
                                                                 // [39:16] mark_count
  output logic [1:0]                               out_tuser,   // [0] is_prime,
                                                                // [1] out_of_range
  input  logic                                     cfg_wr_en,
  input  logic [psb_pkg::CAND_W-1:0]               cfg_wr_data  // upper_limit
);

  import psb_pkg::*;

  localparam int unsigned MAP_TOP = (MAX_NUMBER < 65535) ? MAX_NUMBER : 65535;
  localparam int unsigned ROWS    = (MAP_TOP + ROW_W) / ROW_W;
  localparam int          RAW     = $clog2(ROWS);
  localparam logic [CAND_W-1:0] MAP_TOP_W = CAND_W'(MAP_TOP);
  localparam logic [RAW-1:0]    LAST_ROW  = RAW'(ROWS - 1);

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_WIPE = 6'b000010,
    ST_LOOK = 6'b000100,
    ST_TEST = 6'b001000,
    ST_MARK = 6'b010000,
    ST_DONE = 6'b100000
  } state_t;

  state_t              state_r, state_nxt;
  logic [RAW-1:0]      wipe_r, wipe_nxt;
  logic                pend_r, pend_nxt;
  logic                oor_r, oor_nxt;
  logic                prime_r, prime_nxt;
  logic [CAND_W-1:0]   j_r, j_nxt;
  logic [CAND_W-1:0]   p_r, p_nxt;
  logic [ROW_W-1:0]    buf_r, buf_nxt;
  logic                fresh_r, fresh_nxt;
  logic [PRIME_W-1:0]  prime_total_r, prime_total_nxt;
  logic [MARK_W-1:0]   mark_total_r, mark_total_nxt;
  logic [CAND_W-1:0]   cfg_limit_r, cfg_limit_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic                out_prime_r, out_prime_nxt;
  logic                out_oor_r, out_oor_nxt;
  logic [PRIME_W-1:0]  out_pc_r, out_pc_nxt;
  logic [MARK_W-1:0]   out_mc_r, out_mc_nxt;

  logic [CAND_W-1:0]   lim;
  logic                in_oor;
  logic [ROW_W-1:0]    row_cur;
  logic [ROW_W-1:0]    bit_mask;
  logic [ROW_W-1:0]    row_clr;
  logic [CAND_W:0]     j_sum;
  logic                past_lim;
  logic                row_turn;
  logic                flush;

  logic                wr_en;
  logic [RAW-1:0]      wr_addr;
  logic [ROW_W-1:0]    wr_data;
  logic [RAW-1:0]      rd_addr;
  logic [ROW_W-1:0]    rd_data;

  psb_ram #(
    .WIDTH (ROW_W),
    .DEPTH (ROWS)
  ) u_map (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign lim      = (cfg_limit_r > MAP_TOP_W) ? MAP_TOP_W : cfg_limit_r;
  assign in_oor   = (in_tdata < CAND_MIN) || (in_tdata > lim);
  // the first cycle after a row fetch takes the ram output, later ones the held row
  assign row_cur  = fresh_r ? rd_data : buf_r;
  assign bit_mask = ROW_MSB >> j_r[2:0];
  assign row_clr  = row_cur & ~bit_mask;
  assign j_sum    = {1'b0, j_r} + {1'b0, p_r};
  assign past_lim = j_sum > {1'b0, lim};
  assign row_turn = j_sum[CAND_W:3] != {1'b0, j_r[CAND_W-1:3]};
  assign flush    = past_lim || row_turn;

  always_comb begin
    state_nxt       = state_r;
    wipe_nxt        = wipe_r;
    pend_nxt        = pend_r;
    oor_nxt         = oor_r;
    prime_nxt       = prime_r;
    j_nxt           = j_r;
    p_nxt           = p_r;
    buf_nxt         = buf_r;
    fresh_nxt       = fresh_r;
    prime_total_nxt = prime_total_r;
    mark_total_nxt  = mark_total_r;
    cfg_limit_nxt   = cfg_limit_r;
    out_valid_nxt   = out_valid_r;
    out_prime_nxt   = out_prime_r;
    out_oor_nxt     = out_oor_r;
    out_pc_nxt      = out_pc_r;
    out_mc_nxt      = out_mc_r;
    wr_en           = 1'b0;
    wr_addr         = j_r[RAW+2:3];
    wr_data         = row_clr;
    rd_addr         = j_r[RAW+2:3];

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (cfg_wr_en) begin
      cfg_limit_nxt = cfg_wr_data;
    end

    case (state_r)
      ST_IDLE: begin
        rd_addr = in_tdata[RAW+2:3];
        if (in_tvalid) begin
          j_nxt     = in_tdata;
          p_nxt     = in_tdata;
          oor_nxt   = in_oor;
          prime_nxt = 1'b0;
          if (in_tuser) begin
            prime_total_nxt = '0;
            mark_total_nxt  = '0;
            wipe_nxt        = '0;
            pend_nxt        = 1'b1;
            state_nxt       = ST_WIPE;
          end else if (in_oor) begin
            state_nxt = ST_DONE;
          end else begin
            state_nxt = ST_TEST;
          end
        end
      end
      ST_WIPE: begin
        wr_en    = 1'b1;
        wr_addr  = wipe_r;
        wr_data  = ROW_FULL;
        wipe_nxt = RAW'(wipe_r + 1'b1);
        if (wipe_r == LAST_ROW) begin
          pend_nxt = 1'b0;
          if (!pend_r) begin
            state_nxt = ST_IDLE;
          end else if (oor_r) begin
            state_nxt = ST_DONE;
          end else begin
            state_nxt = ST_LOOK;
          end
        end
      end
      ST_LOOK: begin
        // fetch issued after the sweep so it cannot race the last row write
        state_nxt = ST_TEST;
      end
      ST_TEST: begin
        if (|(rd_data & bit_mask)) begin
          prime_nxt = 1'b1;
          if (prime_total_r != PRIME_MAX) begin
            prime_total_nxt = prime_total_r + 1'b1;
          end
          fresh_nxt = 1'b1;
          state_nxt = ST_MARK;
        end else begin
          state_nxt = ST_DONE;
        end
      end
      ST_MARK: begin
        if (mark_total_r != MARK_MAX) begin
          mark_total_nxt = mark_total_r + 1'b1;
        end
        fresh_nxt = 1'b0;
        buf_nxt   = row_clr;
        j_nxt     = j_sum[CAND_W-1:0];
        if (flush) begin
          wr_en = 1'b1;
          if (past_lim) begin
            state_nxt = ST_DONE;
          end else begin
            rd_addr   = j_sum[RAW+2:3];
            fresh_nxt = 1'b1;
          end
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_prime_nxt = prime_r;
          out_oor_nxt   = oor_r;
          out_pc_nxt    = prime_total_r;
          out_mc_nxt    = mark_total_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_WIPE;
      wipe_r        <= '0;
      pend_r        <= 1'b0;
      fresh_r       <= 1'b0;
      prime_total_r <= '0;
      mark_total_r  <= '0;
      cfg_limit_r   <= LIMIT_RESET;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      wipe_r        <= wipe_nxt;
      pend_r        <= pend_nxt;
      fresh_r       <= fresh_nxt;
      prime_total_r <= prime_total_nxt;
      mark_total_r  <= mark_total_nxt;
      cfg_limit_r   <= cfg_limit_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    oor_r       <= oor_nxt;
    prime_r     <= prime_nxt;
    j_r         <= j_nxt;
    p_r         <= p_nxt;
    buf_r       <= buf_nxt;
    out_prime_r <= out_prime_nxt;
    out_oor_r   <= out_oor_nxt;
    out_pc_r    <= out_pc_nxt;
    out_mc_r    <= out_mc_nxt;
  end

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_mc_r, out_pc_r};
  assign out_tuser  = {out_oor_r, out_prime_r};

  // the map is never written while waiting for a transfer
  a_idle_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> !wr_en)
    else $error("map write while idle");

  // clearing walk stays within the effective limit
  a_mark_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_MARK) |-> (j_r <= lim) && (j_r >= CAND_MIN))
    else $error("clear address beyond limit");

  // counts only grow while an item is being worked on
  a_mark_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |=> (mark_total_r >= $past(mark_total_r)))
    else $error("mark count dropped mid-item");

  a_prime_step: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |=> (prime_total_r == $past(prime_total_r)) ||
                             (prime_total_r == $past(prime_total_r) + 1'b1))
    else $error("prime count jumped");

endmodule
